// ===== hdl/mtcb_pkg.sv =====
// ----------------------------------------------------------------------------
// mtcb_pkg
// Shared types, codes and the control program of the trace capture buffer.
// ----------------------------------------------------------------------------
package mtcb_pkg;

    localparam int N_CHAN    = 8;
    localparam int SAMPLE_W  = 32;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 4;
    localparam int STATUS_W  = 3;
    localparam int PC_W      = 5;

    localparam int DEF_BUFFER_WORDS = 1024;
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_SAMPLE_BITS  = 32;

    typedef enum logic [1:0] {
        CMD_CAPTURE    = 2'd0,
        CMD_START_DUMP = 2'd1,
        CMD_READ       = 2'd2,
        CMD_END_DUMP   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_CAPTURED   = 3'd0,
        ST_SKIPPED    = 3'd1,
        ST_DUMP_START = 3'd2,
        ST_READ_OK    = 3'd3,
        ST_ILLEGAL    = 3'd4,
        ST_DUMP_END   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_END_DUMP,
        OP_CAP_WRITE,
        OP_CAP_FINISH,
        OP_CAP_SKIP,
        OP_DUMP_START,
        OP_RANGE,
        OP_DIV_START,
        OP_BASE,
        OP_RD_ADDR,
        OP_RD_STORE,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_ITEM,
        C_CMD_CAPTURE,
        C_CMD_START,
        C_CMD_READ,
        C_DUMPING,
        C_CH_MORE,
        C_NOT_IN_RANGE,
        C_RPP_ZERO,
        C_DIV_BUSY,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctl_word_t;

    typedef struct packed {
        cmd_t cmd;
        logic dumping;
        logic ch_more;
        logic in_range;
        logic rpp_zero;
        logic div_busy;
    } dp_flags_t;

    typedef struct packed {
        status_t                          status;
        logic [TIME_W-1:0]                start_time;
        logic [TIME_W-1:0]                end_time;
        logic [N_CHAN-1:0][SAMPLE_W-1:0]  value;
    } result_t;

    localparam logic [PC_W-1:0] L_ACCEPT  = 5'd0;
    localparam logic [PC_W-1:0] L_CAPTURE = 5'd5;
    localparam logic [PC_W-1:0] L_CAP_WR  = 5'd6;
    localparam logic [PC_W-1:0] L_SKIP    = 5'd8;
    localparam logic [PC_W-1:0] L_START   = 5'd9;
    localparam logic [PC_W-1:0] L_READ    = 5'd10;
    localparam logic [PC_W-1:0] L_DIV     = 5'd14;
    localparam logic [PC_W-1:0] L_RD_ADDR = 5'd16;
    localparam logic [PC_W-1:0] L_EMIT    = 5'd18;
    localparam logic [PC_W-1:0] L_LAST    = 5'd18;

    function automatic ctl_word_t ucode(input logic [PC_W-1:0] pc);
        ctl_word_t w;
        case (pc)
            5'd0:    w = '{op: OP_ACCEPT,     cond: C_NO_ITEM,      target: L_ACCEPT};
            5'd1:    w = '{op: OP_NOP,        cond: C_CMD_CAPTURE,  target: L_CAPTURE};
            5'd2:    w = '{op: OP_NOP,        cond: C_CMD_START,    target: L_START};
            5'd3:    w = '{op: OP_NOP,        cond: C_CMD_READ,     target: L_READ};
            5'd4:    w = '{op: OP_END_DUMP,   cond: C_ALWAYS,       target: L_EMIT};
            5'd5:    w = '{op: OP_NOP,        cond: C_DUMPING,      target: L_SKIP};
            5'd6:    w = '{op: OP_CAP_WRITE,  cond: C_CH_MORE,      target: L_CAP_WR};
            5'd7:    w = '{op: OP_CAP_FINISH, cond: C_ALWAYS,       target: L_EMIT};
            5'd8:    w = '{op: OP_CAP_SKIP,   cond: C_ALWAYS,       target: L_EMIT};
            5'd9:    w = '{op: OP_DUMP_START, cond: C_ALWAYS,       target: L_EMIT};
            5'd10:   w = '{op: OP_RANGE,      cond: C_NONE,         target: L_ACCEPT};
            5'd11:   w = '{op: OP_NOP,        cond: C_NOT_IN_RANGE, target: L_EMIT};
            5'd12:   w = '{op: OP_NOP,        cond: C_RPP_ZERO,     target: L_EMIT};
            5'd13:   w = '{op: OP_DIV_START,  cond: C_NONE,         target: L_ACCEPT};
            5'd14:   w = '{op: OP_NOP,        cond: C_DIV_BUSY,     target: L_DIV};
            5'd15:   w = '{op: OP_BASE,       cond: C_NONE,         target: L_ACCEPT};
            5'd16:   w = '{op: OP_RD_ADDR,    cond: C_NONE,         target: L_ACCEPT};
            5'd17:   w = '{op: OP_RD_STORE,   cond: C_CH_MORE,      target: L_RD_ADDR};
            5'd18:   w = '{op: OP_EMIT,       cond: C_OUT_BUSY,     target: L_EMIT};
            default: w = '{op: OP_NOP,        cond: C_ALWAYS,       target: L_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/mtcb_div.sv =====
// ----------------------------------------------------------------------------
// mtcb_div
// Restoring radix-2 remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtcb_div #(
    parameter int DIV_W = 11
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [mtcb_pkg::TIME_W-1:0]     dividend,
    input  logic [DIV_W-1:0]                divisor,
    output logic                            busy,
    output logic [DIV_W-1:0]                remainder
);

    localparam int CNT_W = $clog2(mtcb_pkg::TIME_W + 1);

    logic [CNT_W-1:0]               cnt_reg;
    logic [DIV_W-1:0]               rem_reg;
    logic [mtcb_pkg::TIME_W-1:0]    quo_reg;
    logic [DIV_W:0]                 trial;
    logic [DIV_W:0]                 diff;
    logic [DIV_W-1:0]               rem_next;

    always_comb begin
        trial = {rem_reg, quo_reg[mtcb_pkg::TIME_W-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            rem_next = diff[DIV_W-1:0];
        end else begin
            rem_next = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(mtcb_pkg::TIME_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[mtcb_pkg::TIME_W-2:0], 1'b0};
        end
    end

    assign busy      = (cnt_reg != '0);
    assign remainder = rem_reg;

endmodule

// ===== hdl/mtcb_seq.sv =====
// ----------------------------------------------------------------------------
// mtcb_seq
// Step counter and control store; evaluates jump conditions.
// ----------------------------------------------------------------------------
module mtcb_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mtcb_pkg::dp_flags_t     flags,
    input  logic                    in_valid,
    input  logic                    out_busy,
    output mtcb_pkg::ctl_word_t     ctl
);

    logic [mtcb_pkg::PC_W-1:0] pc_reg;
    logic [mtcb_pkg::PC_W-1:0] pc_next;
    logic                      take;

    assign ctl = mtcb_pkg::ucode(pc_reg);

    always_comb begin
        case (ctl.cond)
            mtcb_pkg::C_NONE:         take = 1'b0;
            mtcb_pkg::C_ALWAYS:       take = 1'b1;
            mtcb_pkg::C_NO_ITEM:      take = !in_valid;
            mtcb_pkg::C_CMD_CAPTURE:  take = (flags.cmd == mtcb_pkg::CMD_CAPTURE);
            mtcb_pkg::C_CMD_START:    take = (flags.cmd == mtcb_pkg::CMD_START_DUMP);
            mtcb_pkg::C_CMD_READ:     take = (flags.cmd == mtcb_pkg::CMD_READ);
            mtcb_pkg::C_DUMPING:      take = flags.dumping;
            mtcb_pkg::C_CH_MORE:      take = flags.ch_more;
            mtcb_pkg::C_NOT_IN_RANGE: take = !flags.in_range;
            mtcb_pkg::C_RPP_ZERO:     take = flags.rpp_zero;
            mtcb_pkg::C_DIV_BUSY:     take = flags.div_busy;
            mtcb_pkg::C_OUT_BUSY:     take = out_busy;
            default:                  take = 1'b0;
        endcase
        if (take) begin
            pc_next = ctl.target;
        end else if (pc_reg == mtcb_pkg::L_LAST) begin
            pc_next = mtcb_pkg::L_ACCEPT;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= mtcb_pkg::L_ACCEPT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hdl/mtcb_dp.sv =====
// ----------------------------------------------------------------------------
// mtcb_dp
// Datapath: trace memory, counters, dump window and readback registers.
// ----------------------------------------------------------------------------
module mtcb_dp #(
    parameter int BUFFER_WORDS = mtcb_pkg::DEF_BUFFER_WORDS,
    parameter int SAMPLE_BITS  = mtcb_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  mtcb_pkg::ctl_word_t                                 ctl,
    input  logic                                                in_valid,
    input  mtcb_pkg::cmd_t                                      in_cmd,
    input  logic [mtcb_pkg::TIME_W-1:0]                         in_time,
    input  logic [mtcb_pkg::N_CHAN-1:0][mtcb_pkg::SAMPLE_W-1:0] in_samples,
    input  logic                                                cfg_wr,
    input  logic [mtcb_pkg::COUNT_W-1:0]                        chan_count,
    input  logic [$clog2(BUFFER_WORDS+1)-1:0]                   rpp,
    output mtcb_pkg::dp_flags_t                                 flags,
    output mtcb_pkg::result_t                                   result
);

    localparam int AW   = $clog2(BUFFER_WORDS);
    localparam int IW   = $clog2(BUFFER_WORDS + 1);
    localparam int TW   = mtcb_pkg::TIME_W;
    localparam int PW   = mtcb_pkg::TIME_W + mtcb_pkg::COUNT_W;
    localparam int MW   = IW + mtcb_pkg::COUNT_W;

    logic [SAMPLE_BITS-1:0] mem [BUFFER_WORDS];

    mtcb_pkg::cmd_t                                     cmd_reg;
    logic [TW-1:0]                                      time_reg;
    logic [mtcb_pkg::N_CHAN-1:0][mtcb_pkg::SAMPLE_W-1:0] sample_reg;
    logic [TW-1:0]                                      tick_reg;
    logic [IW-1:0]                                      wi_reg;
    logic [TW-1:0]                                      dump_start_reg;
    logic                                               dump_active_reg;
    logic                                               in_range_reg;
    logic [mtcb_pkg::COUNT_W-1:0]                       ch_reg;
    logic [IW-1:0]                                      addr_reg;
    logic signed [SAMPLE_BITS-1:0]                      rd_data_reg;
    logic                                               rd_ok_reg;
    mtcb_pkg::status_t                                  status_reg;
    logic [mtcb_pkg::N_CHAN-1:0][mtcb_pkg::SAMPLE_W-1:0] value_reg;

    logic                   accept;
    logic                   ch_active;
    logic                   mem_we;
    logic signed [mtcb_pkg::SAMPLE_W-1:0] wr_sample;
    logic [PW-1:0]          prod;
    logic [MW-1:0]          base;
    logic                   div_busy;
    logic [IW-1:0]          div_rem;

    assign accept    = (ctl.op == mtcb_pkg::OP_ACCEPT) && in_valid;
    assign ch_active = (ch_reg < chan_count);
    assign mem_we    = (ctl.op == mtcb_pkg::OP_CAP_WRITE) && ch_active
                       && (wi_reg < IW'(BUFFER_WORDS));
    assign wr_sample = $signed(sample_reg[ch_reg[2:0]]);
    assign prod      = PW'(tick_reg) * PW'(chan_count);
    assign base      = MW'(div_rem) * MW'(chan_count);

    mtcb_div #(
        .DIV_W (IW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ctl.op == mtcb_pkg::OP_DIV_START),
        .dividend  (time_reg),
        .divisor   (rpp),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wi_reg[AW-1:0]] <= SAMPLE_BITS'(wr_sample);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.op == mtcb_pkg::OP_RD_ADDR) begin
            rd_data_reg <= $signed(mem[addr_reg[AW-1:0]]);
            rd_ok_reg   <= (addr_reg < IW'(BUFFER_WORDS));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg        <= '0;
            wi_reg          <= '0;
            dump_start_reg  <= '1;
            dump_active_reg <= 1'b0;
            ch_reg          <= '0;
        end else begin
            case (ctl.op)
                mtcb_pkg::OP_ACCEPT: begin
                    ch_reg <= '0;
                end
                mtcb_pkg::OP_END_DUMP: begin
                    dump_start_reg  <= '1;
                    dump_active_reg <= 1'b0;
                end
                mtcb_pkg::OP_CAP_WRITE: begin
                    if (ch_active) begin
                        wi_reg <= wi_reg + 1'b1;
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                mtcb_pkg::OP_CAP_FINISH: begin
                    if (({1'b0, wi_reg} + (IW+1)'(chan_count)) > (IW+1)'(BUFFER_WORDS)) begin
                        wi_reg <= '0;
                    end
                    tick_reg <= tick_reg + 1'b1;
                end
                mtcb_pkg::OP_DUMP_START: begin
                    if (prod > PW'(BUFFER_WORDS)) begin
                        dump_start_reg <= tick_reg - TW'(rpp);
                    end else begin
                        dump_start_reg <= '0;
                    end
                    dump_active_reg <= 1'b1;
                end
                mtcb_pkg::OP_BASE: begin
                    ch_reg <= '0;
                end
                mtcb_pkg::OP_RD_STORE: begin
                    ch_reg <= ch_reg + 1'b1;
                end
                default: begin
                end
            endcase
            if (cfg_wr) begin
                tick_reg <= '0;
                wi_reg   <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= in_cmd;
            time_reg   <= in_time;
            sample_reg <= in_samples;
            value_reg  <= '0;
        end
        case (ctl.op)
            mtcb_pkg::OP_END_DUMP:   status_reg <= mtcb_pkg::ST_DUMP_END;
            mtcb_pkg::OP_CAP_FINISH: status_reg <= mtcb_pkg::ST_CAPTURED;
            mtcb_pkg::OP_CAP_SKIP:   status_reg <= mtcb_pkg::ST_SKIPPED;
            mtcb_pkg::OP_DUMP_START: status_reg <= mtcb_pkg::ST_DUMP_START;
            mtcb_pkg::OP_RANGE: begin
                in_range_reg <= (time_reg >= dump_start_reg) && (time_reg < tick_reg);
                if ((time_reg >= dump_start_reg) && (time_reg < tick_reg)) begin
                    status_reg <= mtcb_pkg::ST_READ_OK;
                end else begin
                    status_reg <= mtcb_pkg::ST_ILLEGAL;
                end
            end
            mtcb_pkg::OP_BASE: addr_reg <= base[IW-1:0];
            mtcb_pkg::OP_RD_STORE: begin
                addr_reg <= addr_reg + 1'b1;
                if (rd_ok_reg) begin
                    value_reg[ch_reg[2:0]] <= mtcb_pkg::SAMPLE_W'(rd_data_reg);
                end else begin
                    value_reg[ch_reg[2:0]] <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        flags.cmd      = cmd_reg;
        flags.dumping  = dump_active_reg;
        flags.ch_more  = ((ch_reg + 1'b1) < chan_count);
        flags.in_range = in_range_reg;
        flags.rpp_zero = (rpp == '0);
        flags.div_busy = div_busy;
    end

    always_comb begin
        result.status     = status_reg;
        result.start_time = dump_start_reg;
        result.end_time   = tick_reg;
        result.value      = value_reg;
    end

endmodule

// ===== hdl/multichannel_trace_capture_buffer.sv =====
// One transaction is in flight at a time; no new one is accepted until its result
// has been placed in the output register.
// Throughput is limited by the radix-2 remainder unit on reads and by the trace
// memory, which a capture writes and a readback reads one word at a time.
// Reset clears counters and dump state; trace memory content is kept as is.
// ----------------------------------------------------------------------------
// multichannel_trace_capture_buffer
// Multichannel circular trace buffer with dump window and record readback.
// ----------------------------------------------------------------------------
module multichannel_trace_capture_buffer #(
    parameter int BUFFER_WORDS = mtcb_pkg::DEF_BUFFER_WORDS,
    parameter int MAX_CHANNELS = mtcb_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = mtcb_pkg::DEF_SAMPLE_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [31:0]        s_read_time,
    input  logic signed [31:0] s_sample_0,
    input  logic signed [31:0] s_sample_1,
    input  logic signed [31:0] s_sample_2,
    input  logic signed [31:0] s_sample_3,
    input  logic signed [31:0] s_sample_4,
    input  logic signed [31:0] s_sample_5,
    input  logic signed [31:0] s_sample_6,
    input  logic signed [31:0] s_sample_7,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [31:0]        m_start_time,
    output logic [31:0]        m_end_time,
    output logic signed [31:0] m_value_0,
    output logic signed [31:0] m_value_1,
    output logic signed [31:0] m_value_2,
    output logic signed [31:0] m_value_3,
    output logic signed [31:0] m_value_4,
    output logic signed [31:0] m_value_5,
    output logic signed [31:0] m_value_6,
    output logic signed [31:0] m_value_7
);

    localparam int IW = $clog2(BUFFER_WORDS + 1);
    localparam int CW = mtcb_pkg::COUNT_W;
    localparam logic [IW-1:0] RPP_1 = IW'(BUFFER_WORDS / 1);
    localparam logic [IW-1:0] RPP_2 = IW'(BUFFER_WORDS / 2);
    localparam logic [IW-1:0] RPP_3 = IW'(BUFFER_WORDS / 3);
    localparam logic [IW-1:0] RPP_4 = IW'(BUFFER_WORDS / 4);
    localparam logic [IW-1:0] RPP_5 = IW'(BUFFER_WORDS / 5);
    localparam logic [IW-1:0] RPP_6 = IW'(BUFFER_WORDS / 6);
    localparam logic [IW-1:0] RPP_7 = IW'(BUFFER_WORDS / 7);
    localparam logic [IW-1:0] RPP_8 = IW'(BUFFER_WORDS / 8);

    logic [CW-1:0]              count_reg;
    logic [IW-1:0]              rpp_reg;
    logic [CW-1:0]              count_sat;
    logic [IW-1:0]              rpp_sel;
    logic                       cfg_wr;

    logic                       out_valid_reg;
    mtcb_pkg::result_t          out_reg;
    logic                       out_busy;
    logic                       emit;

    mtcb_pkg::ctl_word_t        ctl;
    mtcb_pkg::dp_flags_t        flags;
    mtcb_pkg::result_t          result;
    logic [mtcb_pkg::N_CHAN-1:0][mtcb_pkg::SAMPLE_W-1:0] samples;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign count_sat = (cfg_data > CW'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) : cfg_data;

    always_comb begin
        case (count_sat)
            4'd1:    rpp_sel = RPP_1;
            4'd2:    rpp_sel = RPP_2;
            4'd3:    rpp_sel = RPP_3;
            4'd4:    rpp_sel = RPP_4;
            4'd5:    rpp_sel = RPP_5;
            4'd6:    rpp_sel = RPP_6;
            4'd7:    rpp_sel = RPP_7;
            4'd8:    rpp_sel = RPP_8;
            default: rpp_sel = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rpp_reg   <= '0;
        end else if (cfg_wr) begin
            count_reg <= count_sat;
            rpp_reg   <= rpp_sel;
        end
    end

    assign samples[0] = s_sample_0;
    assign samples[1] = s_sample_1;
    assign samples[2] = s_sample_2;
    assign samples[3] = s_sample_3;
    assign samples[4] = s_sample_4;
    assign samples[5] = s_sample_5;
    assign samples[6] = s_sample_6;
    assign samples[7] = s_sample_7;

    assign s_ready  = (ctl.op == mtcb_pkg::OP_ACCEPT);
    assign out_busy = out_valid_reg && !m_ready;
    assign emit     = (ctl.op == mtcb_pkg::OP_EMIT) && !out_busy;

    mtcb_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .flags    (flags),
        .in_valid (s_valid),
        .out_busy (out_busy),
        .ctl      (ctl)
    );

    mtcb_dp #(
        .BUFFER_WORDS (BUFFER_WORDS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .in_valid   (s_valid),
        .in_cmd     (mtcb_pkg::cmd_t'(s_command)),
        .in_time    (s_read_time),
        .in_samples (samples),
        .cfg_wr     (cfg_wr),
        .chan_count (count_reg),
        .rpp        (rpp_reg),
        .flags      (flags),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_reg.status;
    assign m_start_time = out_reg.start_time;
    assign m_end_time   = out_reg.end_time;
    assign m_value_0    = $signed(out_reg.value[0]);
    assign m_value_1    = $signed(out_reg.value[1]);
    assign m_value_2    = $signed(out_reg.value[2]);
    assign m_value_3    = $signed(out_reg.value[3]);
    assign m_value_4    = $signed(out_reg.value[4]);
    assign m_value_5    = $signed(out_reg.value[5]);
    assign m_value_6    = $signed(out_reg.value[6]);
    assign m_value_7    = $signed(out_reg.value[7]);

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while one is in flight");

    a_values_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != mtcb_pkg::ST_READ_OK) |-> (out_reg.value == '0))
        else $error("nonzero value on a result that is not a readback");

    a_capture_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == mtcb_pkg::ST_CAPTURED) |-> (m_start_time == '1))
        else $error("capture stored while a dump window is open");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the multichannel trace capture buffer. Drives
// capture, dump, read and end-dump transactions with random idle cycles and
// back-pressure, and checks every response field against a cycle-free model
// of the capture memory, tick counter and dump window.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BUF_WORDS    = mtcb_pkg::DEF_BUFFER_WORDS;
    localparam int          MAX_CH       = mtcb_pkg::DEF_MAX_CHANNELS;
    localparam int          TARGET_ITEMS = 1700;
    localparam int          CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        mtcb_pkg::cmd_t                                      cmd;
        logic [mtcb_pkg::TIME_W-1:0]                         read_tick;
        logic [mtcb_pkg::N_CHAN-1:0][mtcb_pkg::SAMPLE_W-1:0] sample;
    } trace_item_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_data  = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command = '0;
    logic [31:0]        s_read_time = '0;
    logic signed [31:0] s_sample_0 = '0;
    logic signed [31:0] s_sample_1 = '0;
    logic signed [31:0] s_sample_2 = '0;
    logic signed [31:0] s_sample_3 = '0;
    logic signed [31:0] s_sample_4 = '0;
    logic signed [31:0] s_sample_5 = '0;
    logic signed [31:0] s_sample_6 = '0;
    logic signed [31:0] s_sample_7 = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [2:0]         m_status;
    logic [31:0]        m_start_time;
    logic [31:0]        m_end_time;
    logic signed [31:0] m_value_0;
    logic signed [31:0] m_value_1;
    logic signed [31:0] m_value_2;
    logic signed [31:0] m_value_3;
    logic signed [31:0] m_value_4;
    logic signed [31:0] m_value_5;
    logic signed [31:0] m_value_6;
    logic signed [31:0] m_value_7;

    logic [mtcb_pkg::N_CHAN-1:0][mtcb_pkg::SAMPLE_W-1:0] m_values;
    assign m_values = {m_value_7, m_value_6, m_value_5, m_value_4,
                       m_value_3, m_value_2, m_value_1, m_value_0};

    // capture buffer model state
    int unsigned       ch_count  = 0;
    int unsigned       rpp       = 0;
    int unsigned       wr_idx    = 0;
    logic [31:0]       ticks     = '0;
    logic [31:0]       dump_from = '1;
    bit                dumping   = 1'b0;
    logic [31:0]       trace_mem [BUF_WORDS];

    mtcb_pkg::result_t pending_responses[$];
    mtcb_pkg::result_t exp_r;
    int                mismatch_count = 0;
    int                items_sent     = 0;
    int                rx_wait        = 0;
    int                cycle_count    = 0;
    bit                gaps_on        = 1'b1;
    logic              hold_off       = 1'b0;

    multichannel_trace_capture_buffer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_read_time  (s_read_time),
        .s_sample_0   (s_sample_0),
        .s_sample_1   (s_sample_1),
        .s_sample_2   (s_sample_2),
        .s_sample_3   (s_sample_3),
        .s_sample_4   (s_sample_4),
        .s_sample_5   (s_sample_5),
        .s_sample_6   (s_sample_6),
        .s_sample_7   (s_sample_7),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_start_time (m_start_time),
        .m_end_time   (m_end_time),
        .m_value_0    (m_value_0),
        .m_value_1    (m_value_1),
        .m_value_2    (m_value_2),
        .m_value_3    (m_value_3),
        .m_value_4    (m_value_4),
        .m_value_5    (m_value_5),
        .m_value_6    (m_value_6),
        .m_value_7    (m_value_7)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("multichannel_trace_capture_buffer regression: fail");
            $finish;
        end
    end

    function automatic mtcb_pkg::result_t predict_response(trace_item_t it);
        mtcb_pkg::result_t r;
        int unsigned       base;
        r = '0;
        case (it.cmd)
            mtcb_pkg::CMD_CAPTURE: begin
                if (dumping) begin
                    r.status = mtcb_pkg::ST_SKIPPED;
                end else begin
                    for (int i = 0; i < ch_count; i++) begin
                        trace_mem[wr_idx] = it.sample[i];
                        wr_idx++;
                    end
                    if (wr_idx + ch_count > BUF_WORDS)
                        wr_idx = 0;
                    ticks++;
                    r.status = mtcb_pkg::ST_CAPTURED;
                end
            end
            mtcb_pkg::CMD_START_DUMP: begin
                if (64'(ticks) * 64'(ch_count) > 64'(BUF_WORDS))
                    dump_from = ticks - rpp;
                else
                    dump_from = '0;
                dumping  = 1'b1;
                r.status = mtcb_pkg::ST_DUMP_START;
            end
            mtcb_pkg::CMD_READ: begin
                if (it.read_tick >= dump_from && it.read_tick < ticks) begin
                    r.status = mtcb_pkg::ST_READ_OK;
                    if (ch_count != 0) begin
                        base = (it.read_tick % rpp) * ch_count;
                        for (int i = 0; i < ch_count; i++)
                            r.value[i] = trace_mem[base + i];
                    end
                end else begin
                    r.status = mtcb_pkg::ST_ILLEGAL;
                end
            end
            default: begin
                dump_from = '1;
                dumping   = 1'b0;
                r.status  = mtcb_pkg::ST_DUMP_END;
            end
        endcase
        r.start_time = dump_from;
        r.end_time   = ticks;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%s mismatch: expected %h, got %h", name, want, got);
        end
    endfunction

    function automatic trace_item_t make_item(mtcb_pkg::cmd_t cmd, logic [31:0] read_tick);
        trace_item_t it;
        it.cmd       = cmd;
        it.read_tick = read_tick;
        for (int i = 0; i < mtcb_pkg::N_CHAN; i++)
            it.sample[i] = $urandom();
        return it;
    endfunction

    function automatic logic [31:0] pick_read_time();
        logic [31:0] span;
        span = ticks - dump_from;
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return dump_from - 1;
            2: return ticks;
            default: begin
                if (dumping && ticks > dump_from)
                    return dump_from + $urandom_range(0, span - 1);
                return $urandom();
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (pending_responses.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: status %0d", m_status);
            end else begin
                exp_r = pending_responses.pop_front();
                compare_field("status", 32'(exp_r.status), 32'(m_status));
                compare_field("start_time", exp_r.start_time, m_start_time);
                compare_field("end_time", exp_r.end_time, m_end_time);
                for (int i = 0; i < mtcb_pkg::N_CHAN; i++)
                    compare_field($sformatf("value_%0d", i), exp_r.value[i], m_values[i]);
            end
            rx_wait = gaps_on ? $urandom_range(0, 15) : 0;
        end else if (m_valid && rx_wait != 0) begin
            rx_wait--;
        end
        m_ready <= !hold_off && rx_wait == 0;
    end

    task automatic send_item(trace_item_t it);
        int                gap;
        mtcb_pkg::result_t exp_item;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= it.cmd;
        s_read_time <= it.read_tick;
        s_sample_0  <= it.sample[0];
        s_sample_1  <= it.sample[1];
        s_sample_2  <= it.sample[2];
        s_sample_3  <= it.sample[3];
        s_sample_4  <= it.sample[4];
        s_sample_5  <= it.sample[5];
        s_sample_6  <= it.sample[6];
        s_sample_7  <= it.sample[7];
        do @(posedge aclk); while (!s_ready);
        exp_item = predict_response(it);
        pending_responses = {pending_responses, exp_item};
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_channels(logic [3:0] code);
        wait_drained();
        cfg_data  <= code;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ch_count = (code > MAX_CH) ? MAX_CH : code;
        rpp      = (ch_count == 0) ? 0 : BUF_WORDS / ch_count;
        ticks    = '0;
        wr_idx   = 0;
    endtask

    // channel count still at its reset value of zero
    task automatic test_reset_defaults();
        send_item(make_item(mtcb_pkg::CMD_READ, 32'd0));
        send_item(make_item(mtcb_pkg::CMD_END_DUMP, $urandom()));
        send_item(make_item(mtcb_pkg::CMD_CAPTURE, $urandom()));
        send_item(make_item(mtcb_pkg::CMD_START_DUMP, $urandom()));
        send_item(make_item(mtcb_pkg::CMD_READ, 32'd0));
        send_item(make_item(mtcb_pkg::CMD_READ, 32'd1));
        send_item(make_item(mtcb_pkg::CMD_CAPTURE, $urandom()));
        send_item(make_item(mtcb_pkg::CMD_START_DUMP, $urandom()));
        send_item(make_item(mtcb_pkg::CMD_END_DUMP, $urandom()));
    endtask

    task automatic test_sample_extremes();
        trace_item_t it;
        write_channels(4'd15);
        it = make_item(mtcb_pkg::CMD_CAPTURE, $urandom());
        it.sample = {32'haaaa_aaaa, 32'h5555_5555, 32'hffff_0000, 32'h0001_0000,
                     32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000};
        send_item(it);
        it.sample = ~it.sample;
        send_item(it);
        send_item(make_item(mtcb_pkg::CMD_START_DUMP, $urandom()));
        send_item(make_item(mtcb_pkg::CMD_READ, 32'd0));
        send_item(make_item(mtcb_pkg::CMD_READ, 32'd1));
        send_item(make_item(mtcb_pkg::CMD_READ, 32'd2));
        send_item(make_item(mtcb_pkg::CMD_READ, 32'hffff_ffff));
        send_item(make_item(mtcb_pkg::CMD_END_DUMP, $urandom()));
    endtask

    task automatic test_config_during_dump();
        write_channels(4'd2);
        send_item(make_item(mtcb_pkg::CMD_CAPTURE, $urandom()));
        send_item(make_item(mtcb_pkg::CMD_START_DUMP, $urandom()));
        write_channels(4'd9);
        send_item(make_item(mtcb_pkg::CMD_READ, 32'd0));
        send_item(make_item(mtcb_pkg::CMD_CAPTURE, $urandom()));
        send_item(make_item(mtcb_pkg::CMD_END_DUMP, $urandom()));
        send_item(make_item(mtcb_pkg::CMD_CAPTURE, $urandom()));
        send_item(make_item(mtcb_pkg::CMD_START_DUMP, $urandom()));
        send_item(make_item(mtcb_pkg::CMD_READ, 32'd0));
        send_item(make_item(mtcb_pkg::CMD_END_DUMP, $urandom()));
    endtask

    task automatic test_backpressure();
        write_channels(4'd8);
        gaps_on = 1'b0;
        hold_off <= 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_off <= 1'b0;
            end
        join_none
        repeat (24) send_item(make_item(mtcb_pkg::CMD_CAPTURE, $urandom()));
        send_item(make_item(mtcb_pkg::CMD_START_DUMP, $urandom()));
        repeat (6) send_item(make_item(mtcb_pkg::CMD_READ, pick_read_time()));
        send_item(make_item(mtcb_pkg::CMD_END_DUMP, $urandom()));
        gaps_on = 1'b1;
    endtask

    task automatic test_capture_sessions();
        logic [3:0] code;
        int         n_cap;
        int         n_rd;
        while (items_sent < TARGET_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       code = 4'd0;
                1:       code = 4'd15;
                2, 3:    code = 4'd8;
                default: code = 4'($urandom_range(1, 14));
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            write_channels(code);
            if (ch_count == 0)
                n_cap = $urandom_range(0, 10);
            else if (rpp <= 180)
                n_cap = $urandom_range(rpp / 2, rpp + 12);
            else
                n_cap = $urandom_range(1, 60);
            repeat (n_cap) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(make_item(mtcb_pkg::cmd_t'($urandom_range(0, 3)), $urandom()));
                else
                    send_item(make_item(mtcb_pkg::CMD_CAPTURE, $urandom()));
            end
            send_item(make_item(mtcb_pkg::CMD_START_DUMP, $urandom()));
            n_rd = $urandom_range(4, 24);
            repeat (n_rd) begin
                case ($urandom_range(0, 9))
                    0:       send_item(make_item(mtcb_pkg::CMD_CAPTURE, $urandom()));
                    1:       send_item(make_item(mtcb_pkg::CMD_START_DUMP, $urandom()));
                    default: send_item(make_item(mtcb_pkg::CMD_READ, pick_read_time()));
                endcase
            end
            // leave some dumps open so the next count write lands mid-dump
            if ($urandom_range(0, 7) != 0)
                send_item(make_item(mtcb_pkg::CMD_END_DUMP, $urandom()));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_sample_extremes();
        test_config_during_dump();
        test_backpressure();
        test_capture_sessions();
        wait_drained();
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("multichannel_trace_capture_buffer regression: pass");
        else
            $display("multichannel_trace_capture_buffer regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mtcb_pkg.sv
hdl/mtcb_div.sv
hdl/mtcb_seq.sv
hdl/mtcb_dp.sv
hdl/multichannel_trace_capture_buffer.sv
dv/testbench.sv
